// ----- hw/rtl/ash_pkg.sv -----
// ash_pkg: constants, register indexes and shared types of the arx stream hash
// depends on nothing; imported by every module of the block

package ash_pkg;

  localparam logic [63:0] HASH_P  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] HASH_M1 = 64'h85EBCA77C2B2AE3D;
  localparam logic [63:0] HASH_M2 = 64'hBF58476D1CE4E5B9;

  localparam int SHIFT_W   = 6;
  localparam int CFG_IDX_W = 8;

  localparam logic [SHIFT_W-1:0] SHIFT_ONE_RST   = 6'd29;
  localparam logic [SHIFT_W-1:0] SHIFT_TWO_RST   = 6'd31;
  localparam logic [SHIFT_W-1:0] SHIFT_THREE_RST = 6'd37;
  localparam logic [SHIFT_W-1:0] SHIFT_FOUR_RST  = 6'd41;

  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_ONE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_TWO   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_THREE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_FOUR  = 8'd3;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } mul_rsp_t;

endpackage

// ----- hw/rtl/ash_mul.sv -----
// ash_mul: 64 x 64 multiplier keeping the low 64 bits, one 32 x 32 partial product a cycle
// depends on ash_pkg

module ash_mul (
  input  logic              clk,
  input  logic              rst,
  input  ash_pkg::mul_req_t req,
  output ash_pkg::mul_rsp_t rsp
);
  import ash_pkg::*;

  logic        busy;
  logic [1:0]  step;
  logic        done;
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] sel_a;
  logic [31:0] sel_b;

  always_comb begin
    case (step)
      2'd1: begin
        sel_a = a[31:0];
        sel_b = b[63:32];
      end
      2'd2: begin
        sel_a = a[63:32];
        sel_b = b[31:0];
      end
      default: begin
        sel_a = a[31:0];
        sel_b = b[31:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // cross products only reach the upper half
  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.a;
      b <= req.b;
    end else if (busy) begin
      prod <= {32'b0, sel_a} * {32'b0, sel_b};
      case (step)
        2'd1: acc <= prod;
        2'd2: acc[63:32] <= acc[63:32] + prod[31:0];
        2'd3: acc[63:32] <= acc[63:32] + prod[31:0];
        default: ;
      endcase
    end
  end

  assign rsp = '{done: done, result: acc};

endmodule

// ----- hw/rtl/ash_fifo.sv -----
// ash_fifo: short queue of merged lane values between front and back
// depends on ash_pkg

module ash_fifo (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  logic [63:0] push_data,
  output logic        pop_valid,
  input  logic        pop_ready,
  output logic [63:0] pop_data
);
  import ash_pkg::*;

  logic [63:0]         mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = count != (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/ash_front.sv -----
// ash_front: takes start and data words, seeds and mixes the four lanes,
// queues the merged lanes at message end; depends on ash_pkg and ash_mul

module ash_front (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [63:0] seed,
  input  logic [31:0] msg_len,
  input  logic [63:0] data,
  output logic        push_valid,
  input  logic        push_ready,
  output logic [63:0] push_data
);
  import ash_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_BASE,
    S_MIX_ONE,
    S_MIX_TWO,
    S_PUSH
  } state_t;

  state_t      state;
  logic [63:0] lane_one;
  logic [63:0] lane_two;
  logic [63:0] lane_three;
  logic [63:0] lane_four;
  logic [63:0] seed_r;
  logic [63:0] base;
  logic [31:0] bytes_left;
  logic [29:0] stripe_words_left;
  logic [1:0]  lane_pointer;
  logic        message_open;

  mul_req_t    mreq;
  mul_rsp_t    mrsp;

  logic        in_accept;
  logic        in_stripe;
  logic        partial;
  logic [1:0]  ptr;
  logic [63:0] mask;
  logic [63:0] word;
  logic [63:0] mixed;
  logic [31:0] bytes_next;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int k);
    return (x << k) | (x >> (64 - k));
  endfunction

  ash_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign in_ready   = state == S_IDLE;
  assign in_accept  = in_valid && in_ready;
  assign push_valid = state == S_PUSH;
  assign push_data  = lane_one ^ lane_two ^ lane_three ^ lane_four;

  assign in_stripe  = stripe_words_left != '0;
  assign ptr        = in_stripe ? lane_pointer : 2'd0;
  assign partial    = !in_stripe && (bytes_left < 32'd8);
  assign mask       = (64'h1 << {bytes_left[2:0], 3'b000}) - 64'h1;
  assign word       = partial ? (data & mask) : data;
  assign bytes_next = partial ? 32'd0 : (bytes_left - 32'd8);

  always_comb begin
    case (ptr)
      2'd0: mixed = rotl64((lane_one ^ word) + lane_two, 11);
      2'd1: mixed = rotl64((lane_two ^ word) + lane_three, 17);
      2'd2: mixed = rotl64((lane_three ^ word) + lane_four, 23);
      default: mixed = rotl64((lane_four ^ word) + lane_one, 57);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      message_open      <= 1'b0;
      bytes_left        <= '0;
      stripe_words_left <= '0;
      lane_pointer      <= '0;
      lane_one          <= '0;
      lane_two          <= '0;
      lane_three        <= '0;
      lane_four         <= '0;
      mreq.start        <= 1'b0;
    end else begin
      mreq.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (command == CMD_START) begin
              seed_r            <= seed;
              bytes_left        <= msg_len;
              stripe_words_left <= {1'b0, msg_len[31:5], 2'b00};
              lane_pointer      <= 2'd0;
              message_open      <= msg_len != 32'd0;
              mreq              <= '{start: 1'b1, a: {32'b0, msg_len}, b: HASH_P};
              state             <= S_LEN;
            end else if (message_open) begin
              case (ptr)
                2'd0: lane_one <= mixed;
                2'd1: lane_two <= mixed;
                2'd2: lane_three <= mixed;
                default: lane_four <= mixed;
              endcase
              if (in_stripe) begin
                lane_pointer      <= lane_pointer + 2'd1;
                stripe_words_left <= stripe_words_left - 30'd1;
              end
              bytes_left <= bytes_next;
              if (bytes_next == 32'd0) begin
                message_open <= 1'b0;
                state        <= S_PUSH;
              end
            end
          end
        end
        S_LEN: begin
          if (mrsp.done) begin
            base  <= seed_r ^ mrsp.result;
            mreq  <= '{start: 1'b1, a: seed_r ^ mrsp.result, b: HASH_P};
            state <= S_BASE;
          end
        end
        S_BASE: begin
          if (mrsp.done) begin
            lane_one <= mrsp.result;
            mreq     <= '{start: 1'b1, a: base, b: HASH_M1};
            state    <= S_MIX_ONE;
          end
        end
        S_MIX_ONE: begin
          if (mrsp.done) begin
            lane_two  <= mrsp.result;
            lane_four <= mrsp.result;
            mreq      <= '{start: 1'b1, a: base, b: HASH_M2};
            state     <= S_MIX_TWO;
          end
        end
        S_MIX_TWO: begin
          if (mrsp.done) begin
            lane_three <= mrsp.result;
            state      <= message_open ? S_IDLE : S_PUSH;
          end
        end
        S_PUSH: begin
          if (push_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    message_open |-> bytes_left != 32'd0)
    else $error("open message with no bytes left");

  a_stripe_needs_open: assert property (@(posedge clk) disable iff (rst)
    stripe_words_left != '0 |-> message_open)
    else $error("stripe words pending with no open message");

  a_done_while_seeding: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |-> (state == S_LEN || state == S_BASE || state == S_MIX_ONE ||
                   state == S_MIX_TWO))
    else $error("multiplier result outside seeding");

endmodule

// ----- hw/rtl/ash_back.sv -----
// ash_back: shift registers and the xorshift-multiply finaliser with output register
// depends on ash_pkg and ash_mul

module ash_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ash_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ash_pkg::SHIFT_W-1:0]   cfg_data,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  logic [63:0]                   pop_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [63:0]                   hash
);
  import ash_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_ONE,
    S_MUL_TWO,
    S_MUL_THREE,
    S_EMIT
  } state_t;

  state_t             state;
  logic [SHIFT_W-1:0] shift_one;
  logic [SHIFT_W-1:0] shift_two;
  logic [SHIFT_W-1:0] shift_three;
  logic [SHIFT_W-1:0] shift_four;
  logic [63:0]        x_r;

  mul_req_t           mreq;
  mul_rsp_t           mrsp;

  logic [63:0]        x_one;
  logic [63:0]        x_two;
  logic [63:0]        x_three;
  logic [63:0]        x_four;

  ash_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign cfg_ready = 1'b1;
  assign pop_ready = state == S_IDLE;

  assign x_one   = pop_data ^ (pop_data >> shift_one);
  assign x_two   = mrsp.result ^ (mrsp.result >> shift_two);
  assign x_three = mrsp.result ^ (mrsp.result >> shift_three);
  assign x_four  = mrsp.result ^ (mrsp.result >> shift_four);

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_one   <= SHIFT_ONE_RST;
      shift_two   <= SHIFT_TWO_RST;
      shift_three <= SHIFT_THREE_RST;
      shift_four  <= SHIFT_FOUR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SHIFT_ONE:   shift_one   <= cfg_data;
        REG_SHIFT_TWO:   shift_two   <= cfg_data;
        REG_SHIFT_THREE: shift_three <= cfg_data;
        REG_SHIFT_FOUR:  shift_four  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      mreq.start <= 1'b0;
    end else begin
      mreq.start <= 1'b0;
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            mreq  <= '{start: 1'b1, a: x_one, b: HASH_M1};
            state <= S_MUL_ONE;
          end
        end
        S_MUL_ONE: begin
          if (mrsp.done) begin
            mreq  <= '{start: 1'b1, a: x_two, b: HASH_M2};
            state <= S_MUL_TWO;
          end
        end
        S_MUL_TWO: begin
          if (mrsp.done) begin
            mreq  <= '{start: 1'b1, a: x_three, b: HASH_P};
            state <= S_MUL_THREE;
          end
        end
        S_MUL_THREE: begin
          if (mrsp.done) begin
            x_r   <= x_four;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            hash      <= x_r;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/arx_stream_hash64_top.sv -----
// arx_stream_hash64_top: streaming four-lane arx 64-bit hash, top level
// depends on ash_pkg, ash_front, ash_fifo and ash_back
//
// usage
//   input channel (in_valid/in_ready): a start word (command 0) carries seed and
//   msg_len; data words (command 1) carry eight message bytes, first byte low.
//   data words with no open message are dropped; a start restarts the hash.
//   output channel (out_valid/out_ready): one hash word per message.
//   config channel (cfg_valid/cfg_ready, always ready): cfg_index 0..3 selects the
//   four finaliser shifts, other indexes are ignored; write only while idle.
// timing
//   a start word runs four 64-bit products on the 32 x 32 multiplier, each of
//   three partial products, before the input channel is ready again.
//   data words are taken one per cycle; after the word that ends a message the
//   front holds the input until the queue takes the merged lanes.
//   after the queue entry is popped, the finaliser runs three products on its
//   own multiplier, then loads the output register.
// reset clears all control state and loads shifts 29, 31, 37, 41.
// a stalled receiver holds the hash in the output register and one more in the
// finaliser; two more wait in the queue and one in the front, which then takes no words.

module arx_stream_hash64_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [63:0]                   seed,
  input  logic [31:0]                   msg_len,
  input  logic [63:0]                   data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [63:0]                   hash,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ash_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ash_pkg::SHIFT_W-1:0]   cfg_data
);
  import ash_pkg::*;

  logic        push_valid;
  logic        push_ready;
  logic [63:0] push_data;
  logic        pop_valid;
  logic        pop_ready;
  logic [63:0] pop_data;

  ash_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .seed       (seed),
    .msg_len    (msg_len),
    .data       (data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ash_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ash_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hash      (hash)
  );

endmodule
